/* sv/tci_pkg.sv */
// shared types, constants and helpers of the time chunk index engine
package tci_pkg;

   // default table depth
   localparam int MAX_CHUNKS_DEF = 16;

   // field and store widths
   localparam int TIME_W  = 63;
   localparam int STORE_W = 64;
   localparam int ROWS_W  = 32;
   localparam int CFG_W   = 32;
   localparam int SPAN_W  = 52;
   localparam int ADDR_W  = 4;

   // seconds to microseconds
   localparam logic [SPAN_W-1:0] US_PER_SEC = 52'd1000000;

   // register reset values
   localparam logic [CFG_W-1:0]  INTERVAL_RST  = 32'd86400;
   localparam logic [CFG_W-1:0]  TARGET_RST    = 32'd1000000;
   localparam logic [CFG_W-1:0]  RETENTION_RST = 32'd0;
   localparam logic [SPAN_W-1:0] SPAN_RST      = 52'(64'd86400 * 64'd1000000);

   // register indexes
   typedef enum logic [1:0] {
      REG_INTERVAL  = 2'd0,
      REG_TARGET    = 2'd1,
      REG_RETENTION = 2'd2
   } reg_index_type;

   // request kinds
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_EXPIRE = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_NONE = 2'd2
   } status_type;

   // request word
   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] time_us;
      logic              new_row;
      logic [TIME_W-1:0] now_us;
   } req_word_type;

   // result word
   typedef struct packed {
      status_type        status;
      logic [3:0]        chunk_slot;
      logic              chunk_created;
      logic [4:0]        chunk_total;
      logic [ROWS_W-1:0] freed_rows;
   } rsp_word_type;

   // one chunk of the table
   typedef struct packed {
      logic [STORE_W-1:0] first_us;
      logic [STORE_W-1:0] end_us;
      logic [ROWS_W-1:0]  rows;
   } chunk_entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               cmp_en;
      logic               shift_up;
      logic               shift_down;
      logic               bump_by_hit;
      logic               new_row;
      logic [TIME_W-1:0]  time_us;
      logic [STORE_W-1:0] end_val;
   } cell_cmd_type;

   // per-cell selects from the controller
   typedef struct packed {
      logic valid;
      logic load;
      logic set_end;
      logic bump;
   } cell_sel_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [CFG_W-1:0]  target_rows;
      logic [SPAN_W-1:0] span_us;
      logic [SPAN_W-1:0] ret_us;
      logic              ret_zero;
   } cfg_view_type;

   // saturating row increment
   function automatic logic [ROWS_W-1:0] rows_bump(logic [ROWS_W-1:0] rows, logic en);
      logic [ROWS_W-1:0] res;
      res = rows;
      if (en && rows != '1) begin
         res = rows + ROWS_W'(1);
      end
      return res;
   endfunction

   // fresh one-microsecond chunk
   function automatic chunk_entry_type new_entry(logic [TIME_W-1:0] t, logic new_row);
      chunk_entry_type e;
      e.first_us = {1'b0, t};
      e.end_us   = {1'b0, t} + STORE_W'(1);
      e.rows     = ROWS_W'(new_row);
      return e;
   endfunction

endpackage

/* sv/tci_config.sv */
// configuration registers with microsecond spans precomputed on write
module tci_config (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tci_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [tci_pkg::CFG_W-1:0]        csr_pwdata,
   output logic [tci_pkg::CFG_W-1:0]        csr_prdata,
   output logic                             csr_pready,
   output tci_pkg::cfg_view_type            cfg
);

   logic [tci_pkg::CFG_W-1:0]  interval_ff, interval_in;
   logic [tci_pkg::CFG_W-1:0]  target_ff, target_in;
   logic [tci_pkg::CFG_W-1:0]  retention_ff, retention_in;
   logic [tci_pkg::SPAN_W-1:0] span_ff, span_in;
   logic [tci_pkg::SPAN_W-1:0] ret_us_ff, ret_us_in;
   logic [tci_pkg::SPAN_W-1:0] wdata_us;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // written value scaled to microseconds
   assign wdata_us = tci_pkg::SPAN_W'({20'd0, csr_pwdata} * tci_pkg::US_PER_SEC);

   // register write decode
   always_comb begin
      interval_in  = interval_ff;
      target_in    = target_ff;
      retention_in = retention_ff;
      span_in      = span_ff;
      ret_us_in    = ret_us_ff;
      if (wr_en) begin
         unique case (tci_pkg::reg_index_type'(csr_paddr[3:2]))
            tci_pkg::REG_INTERVAL: begin
               interval_in = csr_pwdata;
               span_in     = wdata_us;
            end
            tci_pkg::REG_TARGET: begin
               target_in = csr_pwdata;
            end
            tci_pkg::REG_RETENTION: begin
               retention_in = csr_pwdata;
               ret_us_in    = wdata_us;
            end
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (tci_pkg::reg_index_type'(csr_paddr[3:2]))
         tci_pkg::REG_INTERVAL:  csr_prdata = interval_ff;
         tci_pkg::REG_TARGET:    csr_prdata = target_ff;
         tci_pkg::REG_RETENTION: csr_prdata = retention_ff;
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= tci_pkg::INTERVAL_RST;
         target_ff    <= tci_pkg::TARGET_RST;
         retention_ff <= tci_pkg::RETENTION_RST;
         span_ff      <= tci_pkg::SPAN_RST;
         ret_us_ff    <= '0;
      end else begin
         interval_ff  <= interval_in;
         target_ff    <= target_in;
         retention_ff <= retention_in;
         span_ff      <= span_in;
         ret_us_ff    <= ret_us_in;
      end
   end

   assign cfg.target_rows = target_ff;
   assign cfg.span_us     = span_ff;
   assign cfg.ret_us      = ret_us_ff;
   assign cfg.ret_zero    = (retention_ff == '0);

endmodule

/* sv/tci_cell.sv */
// one table slot: holds a chunk, matches a time, shifts with its neighbors
module tci_cell (
   input  logic                      clock,
   input  tci_pkg::cell_cmd_type     cmd,
   input  tci_pkg::cell_sel_type     sel,
   input  tci_pkg::chunk_entry_type  up_in,
   input  tci_pkg::chunk_entry_type  down_in,
   input  logic                      seen_in,
   output tci_pkg::chunk_entry_type  entry,
   output logic                      seen_out,
   output logic                      hit_sel
);

   tci_pkg::chunk_entry_type entry_ff, entry_in;
   logic                     hit_ff, hit_in;
   logic                     bump_mine;
   logic [tci_pkg::STORE_W-1:0] t64;

   assign t64 = {1'b0, cmd.time_us};

   // first matching cell wins, lower cells block the ones above
   assign hit_sel   = hit_ff && !seen_in;
   assign seen_out  = seen_in || hit_ff;
   assign bump_mine = sel.bump || (cmd.bump_by_hit && hit_sel);

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      // containment test
      if (cmd.cmp_en) begin
         hit_in = sel.valid && (t64 >= entry_ff.first_us) && (t64 < entry_ff.end_us);
      end
      // load, shift or update in place
      if (sel.load) begin
         entry_in = tci_pkg::new_entry(cmd.time_us, cmd.new_row);
      end else if (cmd.shift_up) begin
         entry_in = up_in;
      end else if (cmd.shift_down) begin
         entry_in = down_in;
      end else begin
         if (sel.set_end) begin
            entry_in.end_us = cmd.end_val;
         end
         entry_in.rows = tci_pkg::rows_bump(entry_ff.rows, bump_mine && cmd.new_row);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;

endmodule

/* sv/time_chunk_index_engine.sv */
// top level of the time chunk index engine: controller and row of cells
//
//   channel  direction  handshake                   payload
//   req      in         req_valid / req_stall       req_data (req_word_type)
//   rsp      out        rsp_valid / rsp_stall       rsp_data (rsp_word_type)
//   csr      in/out     psel, penable, pready       paddr, pwdata, prdata
//
// every word passes through a compare cycle, where all cells test the time
// in parallel, and then a commit cycle, where the table shifts or updates
// the next word is taken in the commit cycle of the word before it
// commit waits while the result register holds an untaken word
// reset empties the table at once; no clearing pass
module time_chunk_index_engine #(
   parameter int MAX_CHUNKS = tci_pkg::MAX_CHUNKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tci_pkg::req_word_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tci_pkg::rsp_word_type       rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tci_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [tci_pkg::CFG_W-1:0]   csr_pwdata,
   output logic [tci_pkg::CFG_W-1:0]   csr_prdata,
   output logic                        csr_pready
);

   localparam int IDX_W = $clog2(MAX_CHUNKS);
   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CMP    = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   tci_pkg::req_word_type     req_ff;
   tci_pkg::rsp_word_type     rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   tci_pkg::chunk_entry_type  shadow_ff, shadow_in;
   logic                      ge_last_ff, rows_met_ff, over_int_ff, expire_ok_ff;
   tci_pkg::cfg_view_type     cfg;
   tci_pkg::cell_cmd_type     cmd;
   tci_pkg::cell_sel_type     cell_sel [MAX_CHUNKS];
   tci_pkg::chunk_entry_type  cell_entry [MAX_CHUNKS];
   logic [MAX_CHUNKS:0]       seen;
   logic [MAX_CHUNKS-1:0]     hit_sel;
   logic [IDX_W-1:0]          hit_slot, last_idx, load_idx, slot;
   logic                      load_en, end_en, bump_en, shift_up, shift_down, bump_by_hit;
   logic [tci_pkg::STORE_W-1:0] t64, now64, end_val;
   logic                      accept, commit_go, full, created;
   tci_pkg::status_type       status;
   logic [tci_pkg::ROWS_W-1:0] freed;

   tci_config u_config (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake and sequencing
   assign commit_go = (state_ff == S_COMMIT) && !(rsp_valid_ff && rsp_stall);
   assign req_stall = !((state_ff == S_IDLE) || commit_go);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_CMP;
         S_CMP:    state_in = S_COMMIT;
         S_COMMIT: begin
            if (commit_go) state_in = accept ? S_CMP : S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   assign t64      = {1'b0, req_ff.time_us};
   assign now64    = {1'b0, req_ff.now_us};
   assign full     = (count_ff == CNT_W'(MAX_CHUNKS));
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   // compare cycle: tests against the newest chunk and the oldest end
   always_ff @(posedge clock) begin
      if (state_ff == S_CMP) begin
         ge_last_ff   <= t64 >= shadow_ff.end_us;
         rows_met_ff  <= shadow_ff.rows >= cfg.target_rows;
         over_int_ff  <= t64 >= (shadow_ff.first_us + tci_pkg::STORE_W'(cfg.span_us));
         expire_ok_ff <= (cell_entry[0].end_us + tci_pkg::STORE_W'(cfg.ret_us)) < now64;
      end
   end

   // slot of the first matching cell
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         if (hit_sel[i]) hit_slot = hit_slot | IDX_W'(i);
      end
   end

   // commit decision
   always_comb begin
      load_en     = 1'b0;
      end_en      = 1'b0;
      bump_en     = 1'b0;
      shift_up    = 1'b0;
      shift_down  = 1'b0;
      bump_by_hit = 1'b0;
      load_idx    = '0;
      end_val     = t64 + tci_pkg::STORE_W'(1);
      count_in    = count_ff;
      status      = tci_pkg::STATUS_OK;
      slot        = '0;
      created     = 1'b0;
      freed       = '0;
      shadow_in   = shadow_ff;
      if (req_ff.req_type == tci_pkg::REQ_INSERT) begin
         if (count_ff == '0) begin
            // first chunk
            load_en   = 1'b1;
            count_in  = CNT_W'(1);
            created   = 1'b1;
            shadow_in = tci_pkg::new_entry(req_ff.time_us, req_ff.new_row);
         end else if (ge_last_ff) begin
            if (rows_met_ff || over_int_ff) begin
               if (full) begin
                  status = tci_pkg::STATUS_FULL;
               end else begin
                  // seal newest when past the interval, and append
                  end_en    = over_int_ff;
                  end_val   = t64;
                  load_en   = 1'b1;
                  load_idx  = IDX_W'(count_ff);
                  count_in  = count_ff + CNT_W'(1);
                  slot      = IDX_W'(count_ff);
                  created   = 1'b1;
                  shadow_in = tci_pkg::new_entry(req_ff.time_us, req_ff.new_row);
               end
            end else begin
               // extend newest
               end_en           = 1'b1;
               bump_en          = 1'b1;
               slot             = last_idx;
               shadow_in.end_us = end_val;
               shadow_in.rows   = tci_pkg::rows_bump(shadow_ff.rows, req_ff.new_row);
            end
         end else if (seen[MAX_CHUNKS]) begin
            // containing chunk found
            bump_by_hit = 1'b1;
            slot        = hit_slot;
            if (hit_slot == last_idx) begin
               shadow_in.rows = tci_pkg::rows_bump(shadow_ff.rows, req_ff.new_row);
            end
         end else if (full) begin
            status = tci_pkg::STATUS_FULL;
         end else begin
            // prepend at slot zero
            shift_up = 1'b1;
            load_en  = 1'b1;
            count_in = count_ff + CNT_W'(1);
            created  = 1'b1;
         end
      end else begin
         if (cfg.ret_zero || count_ff == '0 || !expire_ok_ff) begin
            status = tci_pkg::STATUS_NONE;
         end else begin
            // drop oldest
            shift_down = 1'b1;
            count_in   = count_ff - CNT_W'(1);
            freed      = cell_entry[0].rows;
         end
      end
   end

   // command to the cells
   assign cmd.cmp_en      = (state_ff == S_CMP);
   assign cmd.shift_up    = commit_go && shift_up;
   assign cmd.shift_down  = commit_go && shift_down;
   assign cmd.bump_by_hit = commit_go && bump_by_hit;
   assign cmd.new_row     = req_ff.new_row;
   assign cmd.time_us     = req_ff.time_us;
   assign cmd.end_val     = end_val;

   // row of cells
   assign seen[0] = 1'b0;
   for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
      tci_pkg::chunk_entry_type up_src, down_src;

      assign cell_sel[g].valid   = CNT_W'(g) < count_ff;
      assign cell_sel[g].load    = commit_go && load_en && (load_idx == IDX_W'(g));
      assign cell_sel[g].set_end = commit_go && end_en && (last_idx == IDX_W'(g));
      assign cell_sel[g].bump    = commit_go && bump_en && (last_idx == IDX_W'(g));

      if (g == 0) begin : g_first
         assign up_src = cell_entry[g];
      end else begin : g_up
         assign up_src = cell_entry[g-1];
      end
      if (g == MAX_CHUNKS - 1) begin : g_last
         assign down_src = cell_entry[g];
      end else begin : g_down
         assign down_src = cell_entry[g+1];
      end

      tci_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .sel      (cell_sel[g]),
         .up_in    (up_src),
         .down_in  (down_src),
         .seen_in  (seen[g]),
         .entry    (cell_entry[g]),
         .seen_out (seen[g+1]),
         .hit_sel  (hit_sel[g])
      );
   end

   // result word
   always_comb begin
      rsp_in.status        = status;
      rsp_in.chunk_slot    = 4'(slot);
      rsp_in.chunk_created = created;
      rsp_in.chunk_total   = 5'(count_in);
      rsp_in.freed_rows    = freed;
   end

   assign rsp_valid_in = commit_go || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit_go) count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept)    req_ff    <= req_data;
      if (commit_go) rsp_ff    <= rsp_in;
      if (commit_go) shadow_ff <= shadow_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
